@@ sv/rhp_pkg.sv @@
// Package for the RGB to HLS pixel converter: shared constants, work item types.
// Depends on nothing; used by the interfaces and every module of the block.
package rhp_pkg;

	localparam int CompW = 8;
	localparam int SumW = CompW + 1;
	localparam int SatNumW = 2 * CompW;
	localparam int HueNumW = 14;
	localparam int HueQW = 6;
	localparam int DivSteps = CompW;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW = $clog2(QueueDepth);
	localparam int QueueCntW = $clog2(QueueDepth + 1);

	localparam logic [CompW-1:0] HueRed = 8'd0;
	localparam logic [CompW-1:0] HueGreen = 8'd85;
	localparam logic [CompW-1:0] HueBlue = 8'd170;
	localparam logic [CompW-1:0] HueTop = 8'd255;
	localparam logic [CompW-1:0] LumMid = 8'd127;
	localparam logic [SumW-1:0] SumTop = 9'd510;
	localparam logic [CompW+6:0] HueScale = 15'd85;

	typedef struct packed {
		logic [SatNumW-1:0] sat_num;
		logic [SumW-1:0]    sat_den;
		logic [HueNumW-1:0] hue_num;
		logic [CompW-1:0]   hue_den;
		logic [CompW-1:0]   hue_base;
		logic               hue_neg;
		logic               grey;
		logic [CompW-1:0]   lum;
		logic               last;
	} work_t;

	typedef struct packed {
		logic [SatNumW-1:0] sat_rem;
		logic [SumW-1:0]    sat_den;
		logic [CompW-1:0]   sat_q;
		logic [HueNumW-1:0] hue_rem;
		logic [CompW-1:0]   hue_den;
		logic [HueQW-1:0]   hue_q;
		logic [CompW-1:0]   hue_base;
		logic               hue_neg;
		logic               grey;
		logic [CompW-1:0]   lum;
		logic               last;
	} div_t;

endpackage

@@ sv/rhp_pix_if.sv @@
// Input channel of the converter: one RGB pixel with its last flag.
// Depends on rhp_pkg for the component width.
interface rhp_pix_if;
	logic                     valid;
	logic                     ready;
	logic [rhp_pkg::CompW-1:0] red;
	logic [rhp_pkg::CompW-1:0] green;
	logic [rhp_pkg::CompW-1:0] blue;
	logic                     last_in;

	modport source (output valid, output red, output green, output blue, output last_in,
		input ready);
	modport sink (input valid, input red, input green, input blue, input last_in,
		output ready);
endinterface

@@ sv/rhp_hls_if.sv @@
// Output channel of the converter: hue, saturation, lightness and last flag.
// Depends on rhp_pkg for the component width.
interface rhp_hls_if;
	logic                     valid;
	logic                     ready;
	logic [rhp_pkg::CompW-1:0] hue;
	logic [rhp_pkg::CompW-1:0] saturation;
	logic [rhp_pkg::CompW-1:0] lightness;
	logic                     last_out;

	modport source (output valid, output hue, output saturation, output lightness,
		output last_out, input ready);
	modport sink (input valid, input hue, input saturation, input lightness,
		input last_out, output ready);
endinterface

@@ sv/rgb_to_hls_pixel.sv @@
// RGB to HLS pixel converter, top level: front end, work queue, divider back end.
// Path from input acceptance to output valid: the front register, then the queue
// write, eight divider stages and the output register.
// Throughput is one pixel per cycle while hls.ready does not stall the output.
// Reset clears the valid flags and queue pointers asynchronously; no clearing pass.
// Depends on rhp_pkg, rhp_pix_if, rhp_hls_if, rhp_front, rhp_queue and rhp_back.
module rgb_to_hls_pixel (
	input  logic      clk,
	input  logic      arst_n,
	rhp_pix_if.sink   pix,
	rhp_hls_if.source hls
);

	logic           f_valid, f_ready, q_valid, q_ready;
	rhp_pkg::work_t f_work, q_work;

	rhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.work_valid (f_valid),
		.work_ready (f_ready),
		.work       (f_work)
	);

	rhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_work),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_work)
	);

	rhp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (q_valid),
		.work_ready (q_ready),
		.work       (q_work),
		.hls        (hls)
	);

endmodule

@@ sv/rhp_front.sv @@
// Front end: finds max and min, lightness, divisors and hue sector of a pixel.
// Depends on rhp_pkg and rhp_pix_if; feeds one registered work item to the queue.
module rhp_front (
	input  logic            clk,
	input  logic            arst_n,
	rhp_pix_if.sink         pix,
	output logic            work_valid,
	input  logic            work_ready,
	output rhp_pkg::work_t  work
);

	logic [rhp_pkg::CompW-1:0] mx, mn, d, t;
	logic [rhp_pkg::SumW-1:0]  sum;
	logic [rhp_pkg::CompW+6:0] hue_prod;
	rhp_pkg::work_t            nxt;
	logic                      valid_s1;
	rhp_pkg::work_t            work_s1;
	logic                      take;

	always_comb begin
		mx = pix.red;
		mn = pix.red;
		if (pix.green > mx) mx = pix.green;
		if (pix.blue > mx) mx = pix.blue;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		sum = rhp_pkg::SumW'(mx) + rhp_pkg::SumW'(mn);
		d = mx - mn;

		nxt.lum = sum[rhp_pkg::SumW-1:1];
		nxt.grey = (mx == mn);
		nxt.last = pix.last_in;
		nxt.sat_num = {d, 8'd0} - rhp_pkg::SatNumW'(d);
		nxt.sat_den = (nxt.lum <= rhp_pkg::LumMid) ? sum : rhp_pkg::SumTop - sum;
		nxt.hue_den = d;

		if (pix.red == mx) begin
			if (pix.green >= pix.blue) begin
				t = pix.green - pix.blue;
				nxt.hue_base = rhp_pkg::HueRed;
				nxt.hue_neg = 1'b0;
			end else begin
				t = pix.blue - pix.green;
				nxt.hue_base = rhp_pkg::HueTop;
				nxt.hue_neg = 1'b1;
			end
		end else if (pix.green == mx) begin
			if (pix.blue >= pix.red) begin
				t = pix.blue - pix.red;
				nxt.hue_base = rhp_pkg::HueGreen;
				nxt.hue_neg = 1'b0;
			end else begin
				t = pix.red - pix.blue;
				nxt.hue_base = rhp_pkg::HueGreen;
				nxt.hue_neg = 1'b1;
			end
		end else begin
			if (pix.red >= pix.green) begin
				t = pix.red - pix.green;
				nxt.hue_base = rhp_pkg::HueBlue;
				nxt.hue_neg = 1'b0;
			end else begin
				t = pix.green - pix.red;
				nxt.hue_base = rhp_pkg::HueBlue;
				nxt.hue_neg = 1'b1;
			end
		end
		hue_prod = 15'(t) * rhp_pkg::HueScale;
		nxt.hue_num = hue_prod[rhp_pkg::HueNumW:1];
	end

	assign take = pix.valid & pix.ready;
	assign pix.ready = ~valid_s1 | work_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1 <= nxt;
		end
	end

	assign work_valid = valid_s1;
	assign work = work_s1;

endmodule

@@ sv/rhp_queue.sv @@
// Short queue of work items between the front end and the divider pipeline.
// Depends on rhp_pkg for the item type and depth.
module rhp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rhp_pkg::work_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rhp_pkg::work_t pop_item
);

	rhp_pkg::work_t                 mem_q [rhp_pkg::QueueDepth];
	logic [rhp_pkg::QueuePtrW-1:0] wr_q, rd_q;
	logic [rhp_pkg::QueueCntW-1:0] cnt_q;
	logic                          push, pop;

	assign push_ready = (cnt_q != rhp_pkg::QueueCntW'(rhp_pkg::QueueDepth));
	assign pop_valid = (cnt_q != '0);
	assign push = push_valid & push_ready;
	assign pop = pop_valid & pop_ready;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push & ~pop) cnt_q <= cnt_q + 1'b1;
			else if (pop & ~push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rhp_pkg::QueueCntW'(rhp_pkg::QueueDepth))
		else $error("queue count above depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == rhp_pkg::QueueCntW'(rhp_pkg::QueueDepth)) |-> wr_q == rd_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

@@ sv/rhp_back.sv @@
// Back end: restoring dividers for saturation and hue, one quotient bit per stage,
// then hue offset, saturation clip and the output register. Depends on rhp_pkg.
module rhp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           work_valid,
	output logic           work_ready,
	input  rhp_pkg::work_t work,
	rhp_hls_if.source      hls
);

	localparam int N = rhp_pkg::DivSteps;

	rhp_pkg::div_t stage_s [N];
	logic          stage_v_s [N];
	rhp_pkg::div_t nxt [N];
	rhp_pkg::div_t head;
	logic          adv [N+1];

	logic                      out_v_q;
	logic [rhp_pkg::CompW-1:0] hue_q, sat_q, lum_q;
	logic                      last_q;
	logic [rhp_pkg::CompW-1:0] hue_n, sat_n;
	logic [rhp_pkg::CompW+1:0] clip;
	rhp_pkg::div_t             fin;

	always_comb begin
		head.sat_rem = work.sat_num;
		head.sat_den = work.sat_den;
		head.sat_q = '0;
		head.hue_rem = work.hue_num;
		head.hue_den = work.hue_den;
		head.hue_q = '0;
		head.hue_base = work.hue_base;
		head.hue_neg = work.hue_neg;
		head.grey = work.grey;
		head.lum = work.lum;
		head.last = work.last;
	end

	assign adv[N] = ~out_v_q | hls.ready;
	assign work_ready = adv[0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int Bit = N - 1 - k;
		rhp_pkg::div_t              prev;
		logic [rhp_pkg::SatNumW-1:0] sat_sh;
		logic [rhp_pkg::HueNumW-1:0] hue_sh;

		if (k == 0) begin : g_first
			assign prev = head;
		end else begin : g_rest
			assign prev = stage_s[k-1];
		end

		assign adv[k] = ~stage_v_s[k] | adv[k+1];

		always_comb begin
			nxt[k] = prev;
			sat_sh = rhp_pkg::SatNumW'(prev.sat_den) << Bit;
			hue_sh = rhp_pkg::HueNumW'(prev.hue_den) << Bit;
			if (prev.sat_rem >= sat_sh) begin
				nxt[k].sat_rem = prev.sat_rem - sat_sh;
				nxt[k].sat_q[Bit] = 1'b1;
			end
			if (Bit < rhp_pkg::HueQW) begin
				if (prev.hue_rem >= hue_sh) begin
					nxt[k].hue_rem = prev.hue_rem - hue_sh;
					nxt[k].hue_q[Bit % rhp_pkg::HueQW] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_v_s[k] <= 1'b0;
			end else if (adv[k]) begin
				if (k == 0) stage_v_s[k] <= work_valid;
				else stage_v_s[k] <= stage_v_s[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				stage_s[k] <= nxt[k];
			end
		end
	end

	assign fin = stage_s[N-1];

	always_comb begin
		if (fin.hue_neg) hue_n = fin.hue_base - rhp_pkg::CompW'(fin.hue_q);
		else hue_n = fin.hue_base + rhp_pkg::CompW'(fin.hue_q);
		if (fin.lum <= rhp_pkg::LumMid) clip = {fin.lum, 2'b00};
		else clip = {rhp_pkg::HueTop - fin.lum, 2'b00};
		sat_n = ((rhp_pkg::CompW+2)'(fin.sat_q) > clip) ? clip[rhp_pkg::CompW-1:0] : fin.sat_q;
		if (fin.grey) begin
			hue_n = '0;
			sat_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv[N]) begin
			out_v_q <= stage_v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[N]) begin
			hue_q <= hue_n;
			sat_q <= sat_n;
			lum_q <= fin.lum;
			last_q <= fin.last;
		end
	end

	assign hls.valid = out_v_q;
	assign hls.hue = hue_q;
	assign hls.saturation = sat_q;
	assign hls.lightness = lum_q;
	assign hls.last_out = last_q;

`ifndef SYNTHESIS
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_v_s[N-1] && out_v_q && !hls.ready) |=> stage_v_s[N-1])
		else $error("last divider stage dropped a stalled pixel");
	a_dark_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && lum_q == '0) |-> sat_q == '0)
		else $error("black pixel with nonzero saturation");
`endif

endmodule

@@ tb/sv/tb_rgb_to_hls_pixel.sv @@
// Testbench for the RGB to HLS pixel converter: a table of directed pixels, then random
// pixels under three idling patterns, checked against known rows or an HLS predictor.
// Depends on rhp_pkg, rhp_pix_if, rhp_hls_if and rgb_to_hls_pixel.
module tb_rgb_to_hls_pixel;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 400000;
	localparam int RandomPerPhase = 509;
	localparam int DrainCycles = 30;
	localparam int PrintCap = 40;

	typedef struct packed {
		logic [rhp_pkg::CompW-1:0] red;
		logic [rhp_pkg::CompW-1:0] green;
		logic [rhp_pkg::CompW-1:0] blue;
		logic                      last;
	} pixel_t;

	typedef struct packed {
		logic [rhp_pkg::CompW-1:0] hue;
		logic [rhp_pkg::CompW-1:0] saturation;
		logic [rhp_pkg::CompW-1:0] lightness;
		logic                      last;
	} hls_t;

	typedef struct packed {
		pixel_t pix;
		hls_t   res;
	} hls_expect_t;

	typedef struct packed {
		logic                      known;
		logic [rhp_pkg::CompW-1:0] red;
		logic [rhp_pkg::CompW-1:0] green;
		logic [rhp_pkg::CompW-1:0] blue;
		logic                      last;
		logic [rhp_pkg::CompW-1:0] hue;
		logic [rhp_pkg::CompW-1:0] saturation;
		logic [rhp_pkg::CompW-1:0] lightness;
	} pixel_row_t;

	// Rows with known set carry their result; the others are checked against the predictor.
	pixel_row_t pixel_rows [24] = '{
		'{1'b1, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b1, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
		'{1'b1, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0,   8'd255, 8'd127},
		'{1'b1, 8'd0,   8'd255, 8'd0,   1'b0, 8'd85,  8'd255, 8'd127},
		'{1'b1, 8'd0,   8'd0,   8'd255, 1'b1, 8'd170, 8'd255, 8'd127},
		'{1'b0, 8'd128, 8'd128, 8'd128, 1'b1, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd1,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd255, 8'd254, 8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd255, 8'd0,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd255, 8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd0,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd128, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd100, 8'd100, 8'd200, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd0,   8'd100, 8'd200, 1'b1, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd200, 8'd0,   8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd100, 8'd200, 8'd50,  1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd50,  8'd200, 8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd200, 8'd55,  8'd100, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd200, 8'd56,  8'd100, 1'b1, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd170, 8'd85,  8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd254, 8'd1,   8'd128, 1'b1, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd255, 8'd0,   8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
		'{1'b0, 8'd0,   8'd1,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0}
	};

	logic clk;
	logic arst_n;

	rhp_pix_if pix_ch ();
	rhp_hls_if hls_ch ();

	rgb_to_hls_pixel dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.hls    (hls_ch)
	);

	hls_expect_t hls_expect_q [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 15;
	int unsigned recv_idle_pct = 87;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned hue_sixth(input int unsigned t, input int unsigned d);
		return ((t * 85) >> 1) / d;
	endfunction

	function automatic hls_t hls_predict(input pixel_t p);
		int unsigned r, g, b, hi, lo, sum, lum, d, sat, hue, clip;
		hls_t q;
		r = p.red;
		g = p.green;
		b = p.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		sum = hi + lo;
		lum = sum >> 1;
		hue = 0;
		sat = 0;
		if (hi != lo) begin
			d = hi - lo;
			sat = (lum <= 127) ? (d * 255) / sum : (d * 255) / (510 - sum);
			if (r == hi) begin
				hue = (g >= b) ? hue_sixth(g - b, d) : 255 - hue_sixth(b - g, d);
			end else if (g == hi) begin
				hue = (b >= r) ? 85 + hue_sixth(b - r, d) : 85 - hue_sixth(r - b, d);
			end else if (r >= g) begin
				hue = 170 + hue_sixth(r - g, d);
				if (hue > 255) hue = 255;
			end else begin
				hue = 170 - hue_sixth(g - r, d);
			end
		end
		clip = (lum < 128) ? (lum << 2) : ((255 - lum) << 2);
		if (sat > clip) sat = clip;
		q.hue = 8'(hue);
		q.saturation = 8'(sat);
		q.lightness = 8'(lum);
		q.last = p.last;
		return q;
	endfunction

	function automatic int unsigned clamp_byte(input int v);
		if (v < 0) return 0;
		if (v > 255) return 255;
		return v;
	endfunction

	function automatic pixel_t random_pixel();
		int unsigned a, b, c, base;
		int unsigned corner [6] = '{0, 1, 127, 128, 254, 255};
		pixel_t p;
		a = $urandom_range(255);
		b = $urandom_range(255);
		c = $urandom_range(255);
		case ($urandom_range(9))
			5: begin
				base = $urandom_range(255);
				a = clamp_byte(int'(base) + int'($urandom_range(6)) - 3);
				b = clamp_byte(int'(base) + int'($urandom_range(6)) - 3);
				c = clamp_byte(int'(base) + int'($urandom_range(6)) - 3);
			end
			6: begin
				a = corner[$urandom_range(5)];
				b = corner[$urandom_range(5)];
				c = corner[$urandom_range(5)];
			end
			7: begin
				b = a;
			end
			8: begin
				a = $urandom_range(255, 128);
				c = clamp_byte(254 + int'($urandom_range(2)) - int'(a));
				b = $urandom_range(a, c);
			end
			9: begin
				base = ($urandom_range(1) != 0) ? 255 : 0;
				a = clamp_byte(int'(base) + int'($urandom_range(12)) - 6);
				b = clamp_byte(int'(base) + int'($urandom_range(12)) - 6);
				c = clamp_byte(int'(base) + int'($urandom_range(12)) - 6);
			end
			default: begin
			end
		endcase
		case ($urandom_range(5))
			0: begin p.red = 8'(a); p.green = 8'(b); p.blue = 8'(c); end
			1: begin p.red = 8'(a); p.green = 8'(c); p.blue = 8'(b); end
			2: begin p.red = 8'(b); p.green = 8'(a); p.blue = 8'(c); end
			3: begin p.red = 8'(b); p.green = 8'(c); p.blue = 8'(a); end
			4: begin p.red = 8'(c); p.green = 8'(a); p.blue = 8'(b); end
			default: begin p.red = 8'(c); p.green = 8'(b); p.blue = 8'(a); end
		endcase
		p.last = ($urandom_range(7) == 0);
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PrintCap) $display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic send_pixel(input pixel_t p, input hls_t res);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red <= p.red;
		pix_ch.green <= p.green;
		pix_ch.blue <= p.blue;
		pix_ch.last_in <= p.last;
		do @(posedge clk); while (!pix_ch.ready);
		hls_expect_q.push_back('{pix: p, res: res});
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		while (hls_expect_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		hls_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			hls_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		hls_t got;
		hls_expect_t want;
		if (arst_n && hls_ch.valid && hls_ch.ready) begin
			got = '{hue: hls_ch.hue, saturation: hls_ch.saturation,
				lightness: hls_ch.lightness, last: hls_ch.last_out};
			if (hls_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result h=%0d s=%0d l=%0d",
					got.hue, got.saturation, got.lightness));
			end else begin
				want = hls_expect_q.pop_front();
				if (got !== want.res) begin
					report_mismatch($sformatf({"rgb %0d,%0d,%0d last %0b: ",
						"got h=%0d s=%0d l=%0d last=%0b, ",
						"expected h=%0d s=%0d l=%0d last=%0b"},
						want.pix.red, want.pix.green, want.pix.blue, want.pix.last,
						got.hue, got.saturation, got.lightness, got.last,
						want.res.hue, want.res.saturation, want.res.lightness,
						want.res.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		pixel_t p;
		hls_t res;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.red = '0;
		pix_ch.green = '0;
		pix_ch.blue = '0;
		pix_ch.last_in = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (pixel_rows[i]) begin
			p = '{red: pixel_rows[i].red, green: pixel_rows[i].green,
				blue: pixel_rows[i].blue, last: pixel_rows[i].last};
			if (pixel_rows[i].known) begin
				res = '{hue: pixel_rows[i].hue, saturation: pixel_rows[i].saturation,
					lightness: pixel_rows[i].lightness, last: pixel_rows[i].last};
			end else begin
				res = hls_predict(p);
			end
			send_pixel(p, res);
		end

		for (int phase = 0; phase < 3; phase++) begin
			if (phase != 0) begin
				wait_for_results();
				send_idle_pct = (phase == 1) ? 87 : 0;
				recv_idle_pct = (phase == 1) ? 15 : 0;
			end
			repeat (RandomPerPhase) begin
				p = random_pixel();
				send_pixel(p, hls_predict(p));
			end
		end

		wait_for_results();
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
